FILE: rtl/core/fbm_pkg.sv
// Shared types, codes and widths for the fuzz byte mutator.
package fbm_pkg;

    localparam int POS_W             = 48;
    localparam int BYTE_W            = 8;
    localparam int ENTRY_IDX_W       = 4;
    localparam int MAP_WORD_W        = 64;
    localparam int MAP_WORD_IDX_W    = 2;
    localparam int RANGE_W           = 2 * POS_W;
    localparam int RANGE_ENTRIES_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int RCOUNT_W   = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FUZZ_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CHECK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 2'd2;

    // mask modes; the fourth code leaves the byte unchanged
    localparam logic [1:0] MODE_XOR   = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_KEEP  = 2'd3;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_RANGE,
        KIND_PROTECT,
        KIND_REFUSE
    } kind_t;

    typedef enum logic [2:0] {
        REASON_APPLIED,
        REASON_OUTSIDE,
        REASON_PROTECTED,
        REASON_ZERO_MASK,
        REASON_REFUSED
    } reason_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                      protect_we;
        logic                      refuse_we;
        logic [MAP_WORD_IDX_W-1:0] word;
        logic [MAP_WORD_W-1:0]     bits;
    } map_wr_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              modified;
        reason_t           skip_reason;
    } result_t;

endpackage

FILE: rtl/core/fbm_if.sv
// Handshake channels of the fuzz byte mutator: input items, results, config writes.
interface fbm_item_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         kind;
    logic [fbm_pkg::POS_W-1:0]          position;
    logic [fbm_pkg::BYTE_W-1:0]         data_byte;
    logic [fbm_pkg::BYTE_W-1:0]         fuzz_mask;
    logic [fbm_pkg::ENTRY_IDX_W-1:0]    entry_index;
    logic [fbm_pkg::POS_W-1:0]          range_start;
    logic [fbm_pkg::POS_W-1:0]          range_end;
    logic [fbm_pkg::MAP_WORD_W-1:0]     table_word;

    modport source (
        output valid, kind, position, data_byte, fuzz_mask, entry_index,
               range_start, range_end, table_word,
        input  ready
    );
    modport sink (
        input  valid, kind, position, data_byte, fuzz_mask, entry_index,
               range_start, range_end, table_word,
        output ready
    );
endinterface

interface fbm_result_if;
    logic                       valid;
    logic                       ready;
    logic [fbm_pkg::BYTE_W-1:0] out_byte;
    logic                       modified;
    logic [2:0]                 skip_reason;

    modport source (output valid, out_byte, modified, skip_reason, input ready);
    modport sink (input valid, out_byte, modified, skip_reason, output ready);
endinterface

interface fbm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fbm_pkg::CFG_IDX_W-1:0]  index;
    logic [fbm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/fuzz_byte_mutator.sv
// Top level of the fuzz byte mutator: control, config registers, range scan, result register.
//
// Each data word carries one stream byte, its file position and a fuzz mask, and gives one
// result word; load words (range entry, protect word, refuse word) give none. A data word
// is scanned against range table entries until a match or the end of the valid list (none
// with range checking off or range_count zero, at most min(range_count, RANGE_ENTRIES)),
// then waits in the finish step for a free result register; the input is held until then.
// The scan uses the single read port of the range table memory, walked one entry a cycle
// into one 48-bit window compare. One data word is in work at a time; the result register
// lets the next word be accepted while the previous result waits. The range table is not
// cleared: entries must be written before they are read; the block does not enforce it.
// The protect and refuse bitmaps reset to zero at once.
module fuzz_byte_mutator #(
    parameter int RANGE_ENTRIES = fbm_pkg::RANGE_ENTRIES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    fbm_item_if.sink     item,
    fbm_result_if.source result,
    fbm_cfg_if.sink      cfg
);

    localparam int IDX_W = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int CW    = $clog2(RANGE_ENTRIES + 1);
    localparam int EW    = (CW > fbm_pkg::RCOUNT_W) ? CW : fbm_pkg::RCOUNT_W;

    // config registers
    logic [1:0]                   fuzz_mode_reg;
    logic                         range_check_reg;
    logic [fbm_pkg::RCOUNT_W-1:0] range_count_reg;

    // control
    fbm_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;
    fbm_pkg::result_t out_data_reg;

    // latched data word payload
    logic [fbm_pkg::POS_W-1:0]  pos_reg;
    logic [fbm_pkg::BYTE_W-1:0] orig_reg;
    logic [fbm_pkg::BYTE_W-1:0] mask_reg;

    logic             item_ready;
    logic             item_fire;
    logic             is_data;
    logic             out_free;
    logic             finish_fire;
    logic [EW-1:0]    rc_ext;
    logic [EW-1:0]    n_eff;
    logic             last_entry;
    logic             scan_needed;
    logic [IDX_W-1:0] rd_addr;
    logic             range_we;
    logic [fbm_pkg::RANGE_W-1:0] rd_data;
    logic [fbm_pkg::POS_W-1:0]   r_start;
    logic [fbm_pkg::POS_W-1:0]   r_end;
    logic             match;
    fbm_pkg::map_wr_t map_wr;
    fbm_pkg::result_t decided;

    assign item_fire = item.valid && item_ready;
    assign is_data   = (item.kind == fbm_pkg::KIND_DATA);
    assign out_free  = !out_valid_reg || result.ready;

    // range_count above the table depth acts as the depth
    assign rc_ext      = EW'(range_count_reg);
    assign n_eff       = (rc_ext > EW'(RANGE_ENTRIES)) ? EW'(RANGE_ENTRIES) : rc_ext;
    assign last_entry  = (EW'(cnt_reg) + EW'(1)) == n_eff;
    assign scan_needed = range_check_reg && (n_eff != '0);

    // entry under compare; start == end is open-ended
    assign r_start = rd_data[fbm_pkg::RANGE_W-1 -: fbm_pkg::POS_W];
    assign r_end   = rd_data[fbm_pkg::POS_W-1:0];
    assign match   = (pos_reg >= r_start) && ((r_start == r_end) || (pos_reg < r_end));

    // config writes: always ready, index beyond the list ignored
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fuzz_mode_reg   <= '0;
            range_check_reg <= 1'b0;
            range_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fbm_pkg::CFG_FUZZ_MODE:   fuzz_mode_reg   <= cfg.data[1:0];
                fbm_pkg::CFG_RANGE_CHECK: range_check_reg <= cfg.data[0];
                fbm_pkg::CFG_RANGE_COUNT: range_count_reg <= cfg.data[fbm_pkg::RCOUNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbm_pkg::S_IDLE:
            begin
                if (item_fire && is_data)
                begin
                    state_next = scan_needed ? fbm_pkg::S_SCAN : fbm_pkg::S_FINISH;
                end
            end
            fbm_pkg::S_SCAN:
            begin
                if (match || last_entry)
                begin
                    state_next = fbm_pkg::S_FINISH;
                end
            end
            fbm_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = fbm_pkg::S_IDLE;
                end
            end
            default: state_next = fbm_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item_ready  = 1'b0;
        finish_fire = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            fbm_pkg::S_IDLE:   item_ready  = 1'b1;
            fbm_pkg::S_SCAN:   rd_addr     = cnt_reg + IDX_W'(1);
            fbm_pkg::S_FINISH: finish_fire = out_free;
            default:           ;
        endcase
    end

    assign item.ready = item_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        hit_next = hit_reg;
        if (item_fire && is_data)
        begin
            cnt_next = '0;
            hit_next = !range_check_reg;
        end
        else if (state_reg == fbm_pkg::S_SCAN)
        begin
            hit_next = match;
            if (!(match || last_entry))
            begin
                cnt_next = cnt_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbm_pkg::S_IDLE;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            pos_reg  <= item.position;
            orig_reg <= item.data_byte;
            mask_reg <= item.fuzz_mask;
        end
        if (finish_fire)
        begin
            out_data_reg <= decided;
        end
    end

    // load words
    assign range_we = item_fire && (item.kind == fbm_pkg::KIND_RANGE)
                      && (int'(item.entry_index) < RANGE_ENTRIES);

    assign map_wr.protect_we = item_fire && (item.kind == fbm_pkg::KIND_PROTECT)
                               && (item.entry_index[fbm_pkg::ENTRY_IDX_W-1:
                                                    fbm_pkg::MAP_WORD_IDX_W] == '0);
    assign map_wr.refuse_we  = item_fire && (item.kind == fbm_pkg::KIND_REFUSE)
                               && (item.entry_index[fbm_pkg::ENTRY_IDX_W-1:
                                                    fbm_pkg::MAP_WORD_IDX_W] == '0);
    assign map_wr.word       = item.entry_index[fbm_pkg::MAP_WORD_IDX_W-1:0];
    assign map_wr.bits       = item.table_word;

    fbm_range_mem #(
        .ENTRIES (RANGE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_range_mem (
        .clk   (clk),
        .we    (range_we),
        .waddr (IDX_W'(item.entry_index)),
        .wdata ({item.range_start, item.range_end}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    fbm_decide u_decide (
        .clk    (clk),
        .rst_n  (rst_n),
        .map_wr (map_wr),
        .hit    (hit_reg),
        .orig   (orig_reg),
        .mask   (mask_reg),
        .mode   (fuzz_mode_reg),
        .result (decided)
    );

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_data_reg.out_byte;
    assign result.modified    = out_data_reg.modified;
    assign result.skip_reason = out_data_reg.skip_reason;

    // a result only appears out of the finish step
    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fbm_pkg::S_FINISH))
        else $error("result valid without finish step");

    // scan index stays within the valid entries
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbm_pkg::S_SCAN) |-> (EW'(cnt_reg) < n_eff))
        else $error("range scan past valid entries");

    // a blocked result holds the finish step
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbm_pkg::S_FINISH && out_valid_reg && !result.ready)
        |=> (state_reg == fbm_pkg::S_FINISH))
        else $error("finish left while result register full");

    // skipped bytes are never reported modified
    a_skip_unmodified: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.skip_reason != fbm_pkg::REASON_APPLIED)
        |-> !out_data_reg.modified)
        else $error("skipped byte flagged modified");

endmodule

FILE: rtl/core/fbm_range_mem.sv
// Range table memory: one write port, one read port with registered read data.
module fbm_range_mem #(
    parameter int ENTRIES = fbm_pkg::RANGE_ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [IDX_W-1:0]            waddr,
    input  logic [fbm_pkg::RANGE_W-1:0] wdata,
    input  logic [IDX_W-1:0]            raddr,
    output logic [fbm_pkg::RANGE_W-1:0] rdata
);

    logic [fbm_pkg::RANGE_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/fbm_decide.sv
// Protect/refuse bitmaps and the per-byte mask application and skip decision.
module fbm_decide (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fbm_pkg::map_wr_t            map_wr,
    input  logic                        hit,
    input  logic [fbm_pkg::BYTE_W-1:0]  orig,
    input  logic [fbm_pkg::BYTE_W-1:0]  mask,
    input  logic [1:0]                  mode,
    output fbm_pkg::result_t            result
);

    localparam int BIT_IDX_W = fbm_pkg::BYTE_W - fbm_pkg::MAP_WORD_IDX_W;
    localparam int WORDS     = 2 ** fbm_pkg::MAP_WORD_IDX_W;

    logic [fbm_pkg::MAP_WORD_W-1:0] protect_reg [WORDS];
    logic [fbm_pkg::MAP_WORD_W-1:0] refuse_reg  [WORDS];
    logic [fbm_pkg::BYTE_W-1:0]     new_val;
    logic                           protect_bit;
    logic                           refuse_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                protect_reg[i] <= '0;
                refuse_reg[i]  <= '0;
            end
        end
        else
        begin
            if (map_wr.protect_we)
            begin
                protect_reg[map_wr.word] <= map_wr.bits;
            end
            if (map_wr.refuse_we)
            begin
                refuse_reg[map_wr.word] <= map_wr.bits;
            end
        end
    end

    always_comb
    begin
        case (mode)
            fbm_pkg::MODE_XOR:   new_val = orig ^ mask;
            fbm_pkg::MODE_SET:   new_val = orig | mask;
            fbm_pkg::MODE_CLEAR: new_val = orig & ~mask;
            default:             new_val = orig;
        endcase
    end

    // top bits pick the word, low bits the bit in it
    assign protect_bit = protect_reg[orig[fbm_pkg::BYTE_W-1 -: fbm_pkg::MAP_WORD_IDX_W]]
                                    [orig[BIT_IDX_W-1:0]];
    assign refuse_bit  = refuse_reg[new_val[fbm_pkg::BYTE_W-1 -: fbm_pkg::MAP_WORD_IDX_W]]
                                   [new_val[BIT_IDX_W-1:0]];

    always_comb
    begin
        result.out_byte    = orig;
        result.modified    = 1'b0;
        result.skip_reason = fbm_pkg::REASON_APPLIED;
        if (!hit)
        begin
            result.skip_reason = fbm_pkg::REASON_OUTSIDE;
        end
        else if (protect_bit)
        begin
            result.skip_reason = fbm_pkg::REASON_PROTECTED;
        end
        else if (mask == '0)
        begin
            result.skip_reason = fbm_pkg::REASON_ZERO_MASK;
        end
        else if (refuse_bit)
        begin
            result.skip_reason = fbm_pkg::REASON_REFUSED;
        end
        else
        begin
            result.out_byte = new_val;
            result.modified = (new_val != orig);
        end
    end

endmodule

FILE: bench/fuzz_byte_mutator_test.sv
// Self-checking bench for fuzz_byte_mutator: directed and random words against a local predictor.
module fuzz_byte_mutator_test;

    localparam int TABLE_DEPTH = fbm_pkg::RANGE_ENTRIES_DEF;
    localparam int POS_W       = fbm_pkg::POS_W;
    localparam int BYTE_W      = fbm_pkg::BYTE_W;
    localparam int ENTRY_IDX_W = fbm_pkg::ENTRY_IDX_W;
    localparam int MAP_WORD_W  = fbm_pkg::MAP_WORD_W;
    localparam int CFG_IDX_W   = fbm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = fbm_pkg::CFG_DATA_W;
    localparam int MAX_GAP     = 13;
    // covers a full 16-entry scan plus slack for a trailing load word
    localparam int SETTLE      = 30;

    // One input word as the bench sees it.
    typedef struct {
        fbm_pkg::kind_t         kind;
        logic [POS_W-1:0]       position;
        logic [BYTE_W-1:0]      data_byte;
        logic [BYTE_W-1:0]      fuzz_mask;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [POS_W-1:0]       range_start;
        logic [POS_W-1:0]       range_end;
        logic [MAP_WORD_W-1:0]  table_word;
    } item_word_t;

    logic clk;
    logic rst_n;

    fbm_item_if   item_ch ();
    fbm_result_if result_ch ();
    fbm_cfg_if    cfg_ch ();

    fuzz_byte_mutator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // ---------------------------------------------------------------
    // Shadow copy of the block's state and registers
    // ---------------------------------------------------------------
    logic [POS_W-1:0] range_lo [TABLE_DEPTH];
    logic [POS_W-1:0] range_hi [TABLE_DEPTH];
    logic [255:0]     protect_bits;
    logic [255:0]     refuse_bits;
    logic [1:0]       cur_mode;
    logic             cur_check;
    logic [4:0]       cur_count;

    fbm_pkg::result_t mutation_queue [$];
    int      fault_count;
    bit      no_gaps;          // both sides run back to back while set
    int      hold_off_cycles;  // receiver picks this up and stalls that long

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic bit position_in_table(logic [POS_W-1:0] pos);
        int n;
        n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
        for (int k = 0; k < n; k++)
        begin
            // start equal to end: open-ended window
            if (pos >= range_lo[k] && (range_lo[k] == range_hi[k] || pos < range_hi[k]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic fbm_pkg::result_t mutate_byte(logic [POS_W-1:0] pos,
                                                     logic [BYTE_W-1:0] orig,
                                                     logic [BYTE_W-1:0] mask);
        fbm_pkg::result_t  r;
        logic [BYTE_W-1:0] nv;
        r.out_byte = orig;
        r.modified = 1'b0;
        if (cur_check && !position_in_table(pos))
            r.skip_reason = fbm_pkg::REASON_OUTSIDE;
        else if (protect_bits[orig])          // protect looks at the original value
            r.skip_reason = fbm_pkg::REASON_PROTECTED;
        else if (mask == '0)
            r.skip_reason = fbm_pkg::REASON_ZERO_MASK;
        else
        begin
            case (cur_mode)
                fbm_pkg::MODE_XOR:   nv = orig ^ mask;
                fbm_pkg::MODE_SET:   nv = orig | mask;
                fbm_pkg::MODE_CLEAR: nv = orig & ~mask;
                default:             nv = orig;   // unused mode code passes the byte through
            endcase
            if (refuse_bits[nv])              // refuse looks at the new value
                r.skip_reason = fbm_pkg::REASON_REFUSED;
            else
            begin
                r.skip_reason = fbm_pkg::REASON_APPLIED;
                r.out_byte    = nv;
                r.modified    = (nv != orig);
            end
        end
        return r;
    endfunction

    // Apply one accepted word to the shadow state; data words queue a prediction.
    task automatic note_accepted_word(item_word_t w);
        case (w.kind)
            fbm_pkg::KIND_DATA:
                mutation_queue.push_back(mutate_byte(w.position, w.data_byte, w.fuzz_mask));
            fbm_pkg::KIND_RANGE:
                if (w.entry_index < TABLE_DEPTH)
                begin
                    range_lo[w.entry_index] = w.range_start;
                    range_hi[w.entry_index] = w.range_end;
                end
            fbm_pkg::KIND_PROTECT:
                if (w.entry_index < 4)
                    protect_bits[w.entry_index*MAP_WORD_W +: MAP_WORD_W] = w.table_word;
            fbm_pkg::KIND_REFUSE:
                if (w.entry_index < 4)
                    refuse_bits[w.entry_index*MAP_WORD_W +: MAP_WORD_W] = w.table_word;
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Word builders; fields the kind does not use carry random noise
    // ---------------------------------------------------------------
    function automatic logic [POS_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[POS_W-1:0];
    endfunction

    function automatic logic [MAP_WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_word_t noise_word();
        item_word_t w;
        w.kind        = fbm_pkg::KIND_DATA;
        w.position    = rand48();
        w.data_byte   = BYTE_W'($urandom);
        w.fuzz_mask   = BYTE_W'($urandom);
        w.entry_index = ENTRY_IDX_W'($urandom);
        w.range_start = rand48();
        w.range_end   = rand48();
        w.table_word  = rand64();
        return w;
    endfunction

    function automatic item_word_t data_word(logic [POS_W-1:0] pos, logic [BYTE_W-1:0] b,
                                             logic [BYTE_W-1:0] mask);
        item_word_t w;
        w           = noise_word();
        w.position  = pos;
        w.data_byte = b;
        w.fuzz_mask = mask;
        return w;
    endfunction

    function automatic item_word_t range_word(int idx, logic [POS_W-1:0] s, logic [POS_W-1:0] e);
        item_word_t w;
        w             = noise_word();
        w.kind        = fbm_pkg::KIND_RANGE;
        w.entry_index = ENTRY_IDX_W'(idx);
        w.range_start = s;
        w.range_end   = e;
        return w;
    endfunction

    function automatic item_word_t map_word(fbm_pkg::kind_t k, int idx,
                                            logic [MAP_WORD_W-1:0] bits);
        item_word_t w;
        w             = noise_word();
        w.kind        = k;
        w.entry_index = ENTRY_IDX_W'(idx);
        w.table_word  = bits;
        return w;
    endfunction

    // Mostly short windows near the low positions the data words use.
    function automatic item_word_t random_range_word(int idx);
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] e;
        int               pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            s = POS_W'($urandom_range(0, 8191));
            e = s;
        end
        else if (pick == 1)
        begin
            s = rand48();
            e = rand48();
        end
        else
        begin
            s = POS_W'($urandom_range(0, 8191));
            e = s + POS_W'($urandom_range(1, 1024));
        end
        return range_word(idx, s, e);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, TABLE_DEPTH - 1);
        if (pick < 15)
            return range_lo[k];
        else if (pick < 25)
            return range_hi[k];
        else if (pick < 35)
            return range_hi[k] - POS_W'(1);
        else if (pick < 85)
            return POS_W'($urandom_range(0, 8191));
        return rand48();
    endfunction

    function automatic logic [MAP_WORD_W-1:0] sparse_bits();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return rand64();
        else if (pick == 2)
            return '1;
        return {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
    endfunction

    function automatic item_word_t random_word();
        int pick;
        int idx;
        logic [BYTE_W-1:0] mask;
        pick = $urandom_range(0, 99);
        idx  = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
        mask = ($urandom_range(0, 11) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255));
        if (pick < 75)
            return data_word(pick_position(), BYTE_W'($urandom), mask);
        else if (pick < 87)
            return random_range_word($urandom_range(0, TABLE_DEPTH - 1));
        else if (pick < 94)
            return map_word(fbm_pkg::KIND_PROTECT, idx, sparse_bits());
        return map_word(fbm_pkg::KIND_REFUSE, idx, sparse_bits());
    endfunction

    // ---------------------------------------------------------------
    // Channel drivers
    // ---------------------------------------------------------------
    // Valid stays high after acceptance; the next call either keeps it up
    // with new content or drops it for the gap.
    task automatic send_word(item_word_t w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= w.kind;
        item_ch.position    <= w.position;
        item_ch.data_byte   <= w.data_byte;
        item_ch.fuzz_mask   <= w.fuzz_mask;
        item_ch.entry_index <= w.entry_index;
        item_ch.range_start <= w.range_start;
        item_ch.range_end   <= w.range_end;
        item_ch.table_word  <= w.table_word;
        do @(posedge clk); while (!item_ch.ready);
        note_accepted_word(w);
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic drain_block();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (mutation_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            fbm_pkg::CFG_FUZZ_MODE:   cur_mode  = value[1:0];
            fbm_pkg::CFG_RANGE_CHECK: cur_check = value[0];
            fbm_pkg::CFG_RANGE_COUNT: cur_count = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_mode(logic [1:0] mode);
        write_register(fbm_pkg::CFG_FUZZ_MODE, CFG_DATA_W'(mode));
    endtask

    // ---------------------------------------------------------------
    // Result receiver and checker
    // ---------------------------------------------------------------
    initial
    begin
        int               stall;
        fbm_pkg::result_t exp_r;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            // long hold-off requested by the stall test, counted here
            if (hold_off_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            if (mutation_queue.size() == 0)
            begin
                fault_count++;
                $display("%0t: result word with nothing expected: out_byte %02h", $time,
                         result_ch.out_byte);
            end
            else
            begin
                exp_r = mutation_queue.pop_front();
                if (result_ch.out_byte !== exp_r.out_byte)
                begin
                    fault_count++;
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             exp_r.out_byte, result_ch.out_byte);
                end
                if (result_ch.modified !== exp_r.modified)
                begin
                    fault_count++;
                    $display("%0t: modified expected %0b actual %0b", $time,
                             exp_r.modified, result_ch.modified);
                end
                if (result_ch.skip_reason !== exp_r.skip_reason)
                begin
                    fault_count++;
                    $display("%0t: skip_reason expected %0d actual %0d", $time,
                             exp_r.skip_reason, result_ch.skip_reason);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset state: xor mode, no range check, empty bitmaps.
    task automatic test_power_on_defaults();
        send_word(data_word('0, 8'h00, 8'hFF));
        send_word(data_word('1, 8'hFF, 8'h00));      // zero mask
    endtask

    // Bitmap loads, one ignored word index, then a protected and a refused byte.
    task automatic test_bitmap_loads();
        send_word(map_word(fbm_pkg::KIND_PROTECT, 1, 64'h0000_0000_0000_0002));  // value 0x41
        send_word(map_word(fbm_pkg::KIND_REFUSE, 0, 64'h0000_0000_0000_8000));   // value 0x0F
        send_word(map_word(fbm_pkg::KIND_PROTECT, 15, '1));                      // beyond word 3
        send_word(data_word(48'h10, 8'h41, 8'h01));
        send_word(data_word(48'h11, 8'hF0, 8'hFF));                              // lands on 0x0F
    endtask

    // Set, clear and the unused mode code, including a no-change OR.
    task automatic test_mask_modes();
        drain_block();
        write_mode(fbm_pkg::MODE_SET);
        send_word(data_word(48'h20, 8'h12, 8'h81));
        send_word(data_word(48'h21, 8'hFF, 8'h01));  // bits already set
        drain_block();
        write_mode(fbm_pkg::MODE_CLEAR);
        send_word(data_word(48'h22, 8'hFF, 8'h0F));
        drain_block();
        write_mode(fbm_pkg::MODE_KEEP);
        send_word(data_word(48'h23, 8'h5A, 8'h3C));  // passes through unchanged
        send_word(data_word(48'h24, 8'h0F, 8'h01));  // unchanged value still refused
    endtask

    // Window edges, an open-ended entry, an empty entry and a zero count.
    task automatic test_range_windows();
        send_word(range_word(0, 48'h100, 48'h200));
        send_word(range_word(1, 48'hFFFF_0000_0000, 48'hFFFF_0000_0000));
        send_word(range_word(2, 48'h1000, 48'h1010));
        send_word(range_word(3, 48'h500, 48'h400));  // end below start: never matches
        drain_block();
        write_mode(fbm_pkg::MODE_XOR);
        write_register(fbm_pkg::CFG_RANGE_CHECK, 5'd1);
        write_register(fbm_pkg::CFG_RANGE_COUNT, 5'd0);
        send_word(data_word(48'h150, 8'h00, 8'h55));  // no valid ranges
        drain_block();
        write_register(fbm_pkg::CFG_RANGE_COUNT, 5'd1);
        send_word(data_word(48'h100, 8'h00, 8'h55));
        send_word(data_word(48'h1FF, 8'h00, 8'h55));
        send_word(data_word(48'h200, 8'h00, 8'h55));
        drain_block();
        write_register(fbm_pkg::CFG_RANGE_COUNT, 5'd4);
        send_word(data_word('1, 8'h00, 8'h55));
        send_word(data_word(48'h450, 8'h00, 8'h55));
        drain_block();
        write_register(fbm_pkg::CFG_RANGE_CHECK, 5'd0);
    endtask

    // Fill the whole table first so no scan ever reads an unwritten entry,
    // then run phases of mixed traffic under changing register settings.
    task automatic test_random_traffic();
        logic [4:0] count;
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_word(random_range_word(k));
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_block();
            case (phase % 4)
                0:       count = 5'd0;
                1:       count = 5'd31;   // above table depth
                2:       count = 5'd16;
                default: count = 5'($urandom_range(0, 31));
            endcase
            write_mode((phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3)));
            write_register(fbm_pkg::CFG_RANGE_CHECK, (phase % 3 != 2) ? 5'd1 : 5'd0);
            write_register(fbm_pkg::CFG_RANGE_COUNT, count);
            no_gaps = (phase == 3);
            for (int n = 0; n < 220; n++)
                send_word(random_word());
            no_gaps = 1'b0;
        end
    endtask

    // Receiver holds off while the sender keeps pushing, so the block backs up.
    task automatic test_output_stall();
        drain_block();
        hold_off_cycles = 300;
        no_gaps         = 1'b1;
        for (int n = 0; n < 40; n++)
            send_word(data_word(pick_position(), BYTE_W'($urandom), BYTE_W'($urandom)));
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.kind        = '0;
        item_ch.position    = '0;
        item_ch.data_byte   = '0;
        item_ch.fuzz_mask   = '0;
        item_ch.entry_index = '0;
        item_ch.range_start = '0;
        item_ch.range_end   = '0;
        item_ch.table_word  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        fault_count         = 0;
        no_gaps             = 1'b0;
        hold_off_cycles     = 0;
        protect_bits        = '0;
        refuse_bits         = '0;
        cur_mode            = fbm_pkg::MODE_XOR;
        cur_check           = 1'b0;
        cur_count           = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            range_lo[k] = '0;
            range_hi[k] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_bitmap_loads();
        test_mask_modes();
        test_range_windows();
        test_random_traffic();
        test_output_stall();
        drain_block();

        if (fault_count == 0 && mutation_queue.size() == 0)
            $display("fuzz_byte_mutator verification clean");
        else
            $display("fuzz_byte_mutator verification failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #5000000;
        $display("fuzz_byte_mutator verification failed");
        $finish;
    end

endmodule
